// ===== rtl/core/nrcp_pkg.sv =====
// ----------------------------------------------------------------------------
// nrcp_pkg
// Shared types and constants of the remote command sentence parser.
// ----------------------------------------------------------------------------
package nrcp_pkg;

    localparam int ARG_BITS_DEF  = 16;
    localparam int VOLUME_MAX    = 100;
    localparam int VOLUME_RESET  = 50;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 48;

    // sentence characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_G      = 8'h67;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_W      = 8'h77;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_X      = 8'h78;

    typedef enum logic [3:0] {
        ACT_NONE       = 4'd0,
        ACT_MODE_SET   = 4'd1,
        ACT_VOL_SET    = 4'd2,
        ACT_VOL_LIMIT  = 4'd3,
        ACT_SHORT      = 4'd4,
        ACT_LONG       = 4'd5,
        ACT_UP         = 4'd6,
        ACT_DOWN       = 4'd7,
        ACT_ESCAPE     = 4'd8,
        ACT_GEAR_OFF   = 4'd9,
        ACT_GEAR_ON    = 4'd10,
        ACT_CKS_ERR    = 4'd11
    } t_action;

    typedef struct packed {
        logic [7:0]         cks_computed;
        logic [7:0]         cks_received;
        logic               gear_warn;
        logic [6:0]         volume;
        logic signed [15:0] mode_value;
        t_action            action;
    } t_result;

endpackage

// ===== rtl/core/nrcp_sentence.sv =====
// ----------------------------------------------------------------------------
// nrcp_sentence
// Sentence state: prefix and command parse, argument, checksum, and the
// end-of-sentence action with the volume and gear warning registers.
// ----------------------------------------------------------------------------
module nrcp_sentence
    import nrcp_pkg::*;
#(
    parameter int ARG_BITS = ARG_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data,
    output t_result    o_result
);

    typedef enum logic [11:0] {
        PH_DOLLAR   = 12'b0000_0000_0001,
        PH_G        = 12'b0000_0000_0010,
        PH_COMMA    = 12'b0000_0000_0100,
        PH_CMD      = 12'b0000_0000_1000,
        PH_ARG_WS   = 12'b0000_0001_0000,
        PH_ARG_SIGN = 12'b0000_0010_0000,
        PH_ARG_DIG  = 12'b0000_0100_0000,
        PH_ROT      = 12'b0000_1000_0000,
        PH_ROT_STAR = 12'b0001_0000_0000,
        PH_HEX      = 12'b0010_0000_0000,
        PH_DONE     = 12'b0100_0000_0000,
        PH_BAD      = 12'b1000_0000_0000
    } t_phase;

    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_S    = 3'd1,
        CMD_V    = 3'd2,
        CMD_R    = 3'd3,
        CMD_W    = 3'd4
    } t_cmd;

    localparam int MW = ARG_BITS + 4;
    localparam int VW = ARG_BITS + 2;
    localparam logic [MW-1:0]       CAP_M = MW'(1) << (ARG_BITS - 1);
    localparam logic [ARG_BITS-1:0] CAP_A = ARG_BITS'(1) << (ARG_BITS - 1);

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_0 && c <= CH_9) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    t_phase              r_phase,   n_phase;
    t_cmd                r_cmd,     n_cmd;
    logic [7:0]          r_xor,     n_xor;
    logic [ARG_BITS-1:0] r_acc,     n_acc;
    logic                r_neg,     n_neg;
    logic [7:0]          r_rot,     n_rot;
    logic [7:0]          r_hex,     n_hex;
    logic [1:0]          r_hex_cnt, n_hex_cnt;
    logic                r_star,    n_star;
    logic [6:0]          r_volume,  n_volume;
    logic                r_gear,    n_gear;

    logic [MW-1:0]         acc_mul;
    logic [ARG_BITS-1:0]   acc_new;
    logic [4:0]            hv;
    logic                  sentence_ok;
    logic signed [ARG_BITS:0] a_val;
    logic signed [VW-1:0]  vol_sum;
    logic                  vol_ok;
    logic signed [63:0]    a_ext;
    logic signed [15:0]    mode;
    t_action               act;
    logic [6:0]            cfg_volume;

    // digit append: acc * 10 + digit, saturated at the magnitude cap
    always_comb begin
        acc_mul = (MW'(r_acc) << 3) + (MW'(r_acc) << 1) + MW'(4'(i_ch - CH_0));
        acc_new = (acc_mul > CAP_M) ? CAP_A : acc_mul[ARG_BITS-1:0];
        hv      = hex_val(i_ch);
    end

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_xor     = r_xor;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_rot     = r_rot;
        n_hex     = r_hex;
        n_hex_cnt = r_hex_cnt;
        n_star    = r_star;

        if (!r_star) begin
            if (i_ch == CH_STAR) begin
                n_star = 1'b1;
            end else if (i_ch != CH_DOLLAR && i_ch != CH_BANG) begin
                n_xor = r_xor ^ i_ch;
            end
        end

        unique case (r_phase)
            PH_DOLLAR: n_phase = (i_ch == CH_DOLLAR) ? PH_G : PH_BAD;
            PH_G:      n_phase = (i_ch == CH_G) ? PH_COMMA : PH_BAD;
            PH_COMMA:  n_phase = (i_ch == CH_COMMA) ? PH_CMD : PH_BAD;
            PH_CMD: begin
                if (i_ch == CH_S) begin
                    n_cmd = CMD_S;  n_phase = PH_ARG_WS;
                end else if (i_ch == CH_V) begin
                    n_cmd = CMD_V;  n_phase = PH_ARG_WS;
                end else if (i_ch == CH_W) begin
                    n_cmd = CMD_W;  n_phase = PH_ARG_WS;
                end else if (i_ch == CH_R) begin
                    n_cmd = CMD_R;  n_phase = PH_ROT;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_ARG_WS: begin
                if (is_space(i_ch)) begin
                    n_phase = PH_ARG_WS;
                end else if (i_ch == CH_MINUS) begin
                    n_neg = 1'b1;  n_phase = PH_ARG_SIGN;
                end else if (i_ch == CH_PLUS) begin
                    n_phase = PH_ARG_SIGN;
                end else if (is_digit(i_ch)) begin
                    n_acc = acc_new;  n_phase = PH_ARG_DIG;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_ARG_SIGN: begin
                if (is_digit(i_ch)) begin
                    n_acc = acc_new;  n_phase = PH_ARG_DIG;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_ARG_DIG: begin
                if (is_digit(i_ch)) begin
                    n_acc = acc_new;
                end else begin
                    n_phase = (i_ch == CH_STAR) ? PH_HEX : PH_BAD;
                end
            end
            PH_ROT: begin
                n_rot   = i_ch;
                n_phase = PH_ROT_STAR;
            end
            PH_ROT_STAR: n_phase = (i_ch == CH_STAR) ? PH_HEX : PH_BAD;
            PH_HEX: begin
                if (hv[4]) begin
                    n_hex     = {r_hex[3:0], hv[3:0]};
                    n_hex_cnt = r_hex_cnt + 2'd1;
                    if (r_hex_cnt != 2'd0) begin
                        n_phase = PH_DONE;
                    end
                end else if (r_hex_cnt == 2'd0 && is_space(i_ch)) begin
                    n_phase = PH_HEX;
                end else begin
                    n_phase = (r_hex_cnt != 2'd0) ? PH_DONE : PH_BAD;
                end
            end
            PH_DONE: n_phase = PH_DONE;
            default: n_phase = PH_BAD;
        endcase
    end

    // end-of-sentence evaluation on the updated state
    always_comb begin
        sentence_ok = (n_phase == PH_DONE) || (n_phase == PH_HEX && n_hex_cnt != 2'd0);

        if (n_neg) begin
            a_val = -$signed({1'b0, n_acc});
        end else if (n_acc == CAP_A) begin
            a_val = $signed({1'b0, ARG_BITS'(CAP_A - ARG_BITS'(1))});
        end else begin
            a_val = $signed({1'b0, n_acc});
        end

        vol_sum = VW'(a_val) + $signed(VW'(r_volume));
        vol_ok  = !vol_sum[VW-1] && (vol_sum <= $signed(VW'(VOLUME_MAX)));
        a_ext   = 64'(a_val);

        act      = ACT_NONE;
        mode     = 16'sd0;
        n_volume = r_volume;
        n_gear   = r_gear;

        if (sentence_ok) begin
            if (n_xor != n_hex) begin
                act = ACT_CKS_ERR;
            end else begin
                unique case (n_cmd)
                    CMD_S: begin
                        act  = ACT_MODE_SET;
                        mode = a_ext[15:0];
                    end
                    CMD_V: begin
                        if (vol_ok) begin
                            act      = ACT_VOL_SET;
                            n_volume = vol_sum[6:0];
                        end else begin
                            act = ACT_VOL_LIMIT;
                        end
                    end
                    CMD_R: begin
                        priority if (n_rot == CH_P) act = ACT_SHORT;
                        else if (n_rot == CH_L)     act = ACT_LONG;
                        else if (n_rot == CH_U)     act = ACT_UP;
                        else if (n_rot == CH_D)     act = ACT_DOWN;
                        else if (n_rot == CH_X)     act = ACT_ESCAPE;
                        else                        act = ACT_NONE;
                    end
                    CMD_W: begin
                        if (a_val == '0) begin
                            act    = ACT_GEAR_OFF;
                            n_gear = 1'b0;
                        end else if (a_val == (ARG_BITS+1)'(1)) begin
                            act    = ACT_GEAR_ON;
                            n_gear = 1'b1;
                        end
                    end
                    default: act = ACT_NONE;
                endcase
            end
        end

        o_result.action       = act;
        o_result.mode_value   = mode;
        o_result.volume       = n_volume;
        o_result.gear_warn    = n_gear;
        o_result.cks_received = n_hex;
        o_result.cks_computed = n_xor;
    end

    assign cfg_volume = (i_cfg_wr_data > 7'(VOLUME_MAX)) ? 7'(VOLUME_MAX) : i_cfg_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_DOLLAR;
            r_cmd     <= CMD_NONE;
            r_xor     <= '0;
            r_acc     <= '0;
            r_neg     <= 1'b0;
            r_rot     <= '0;
            r_hex     <= '0;
            r_hex_cnt <= '0;
            r_star    <= 1'b0;
            r_volume  <= 7'(VOLUME_RESET);
            r_gear    <= 1'b0;
        end else begin
            if (i_step) begin
                if (i_last) begin
                    // sentence closed: back to the start of a new one
                    r_phase   <= PH_DOLLAR;
                    r_cmd     <= CMD_NONE;
                    r_xor     <= '0;
                    r_acc     <= '0;
                    r_neg     <= 1'b0;
                    r_rot     <= '0;
                    r_hex     <= '0;
                    r_hex_cnt <= '0;
                    r_star    <= 1'b0;
                    r_gear    <= n_gear;
                end else begin
                    r_phase   <= n_phase;
                    r_cmd     <= n_cmd;
                    r_xor     <= n_xor;
                    r_acc     <= n_acc;
                    r_neg     <= n_neg;
                    r_rot     <= n_rot;
                    r_hex     <= n_hex;
                    r_hex_cnt <= n_hex_cnt;
                    r_star    <= n_star;
                end
            end
            if (i_cfg_wr_en) begin
                r_volume <= cfg_volume;
            end else if (i_step && i_last) begin
                r_volume <= n_volume;
            end
        end
    end

endmodule

// ===== rtl/core/nmea_remote_command_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_remote_command_parser
// Remote control sentence parser with XOR checksum check.
// ----------------------------------------------------------------------------
// Usage:
//   Characters of a "$g,<cmd>..." sentence enter on the s_axis channel, one
//   per transfer, with tlast on the final character. For every tlast the
//   block sends one result transfer on m_axis: action code, mode argument,
//   current volume, gear warning flag, received and computed checksums.
//   Other characters produce no output.
//   One character is taken per cycle except while a closing character
//   waits. A character is held in the input register and evaluated from
//   there; its result is loaded into the result register, which drives m_axis.
//   When the receiver stalls, the result register holds; characters that do
//   not close a sentence keep flowing, a closing character waits in the
//   input register until the result register is free.
//   Reset clears the sentence state, the gear flag and both registers, and
//   sets the volume to 50. A write on the cfg port loads the volume
//   (clamped to 100) and is expected only while no sentence is in flight.
// ----------------------------------------------------------------------------
module nmea_remote_command_parser
    import nrcp_pkg::*;
#(
    parameter int ARG_BITS = ARG_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [7:0] ch
    input  logic                   i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [3:0] action, [19:4] mode_value, [26:20] volume, [27] gear_warn,
    // [35:28] checksum_received, [43:36] checksum_computed, rest zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_wr_en,
    input  logic [6:0]             i_cfg_wr_data
);

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       step;
    logic       in_take;
    t_result    result;

    assign out_free = !r_out_valid || i_m_axis_tready;
    // a closing character needs room in the result register
    assign step     = r_in_valid && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_valid || step;
    assign in_take  = i_s_axis_tvalid && o_s_axis_tready;

    nrcp_sentence #(
        .ARG_BITS (ARG_BITS)
    ) u_sentence (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_ch          (r_in_ch),
        .i_last        (r_in_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !step);
            if (step && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_ch   <= i_s_axis_tdata[7:0];
            r_in_last <= i_s_axis_tlast;
        end
        if (step && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.cks_computed, r_out.cks_received,
                              r_out.gear_warn, r_out.volume, r_out.mode_value,
                              r_out.action};

endmodule
